>>> rtl/core/ps2a_pkg.sv
// Package with shared constants, register indexes and the brightness ramp.
`timescale 1ns / 1ps

package ps2a_pkg;

  // Widths of the configuration port and the beat payloads.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 29;
  localparam int DIM_W      = 13;
  localparam int STEP_W     = 29;
  localparam int POS_W      = 30;
  localparam int POS_FRAC_W = 16;
  localparam int CHAN_W     = 8;
  localparam int PIX_DATA_W = 4 * CHAN_W;
  localparam int OUT_DATA_W = 4 * CHAN_W;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DEST_WIDTH  = 3'd2,
    REG_DEST_HEIGHT = 3'd3,
    REG_STEP_Q16    = 3'd4,
    REG_ALPHA_EN    = 3'd5
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]  SRC_WIDTH_RST   = 13'd640;
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST  = 13'd480;
  localparam logic [DIM_W-1:0]  DEST_WIDTH_RST  = 13'd600;
  localparam logic [DIM_W-1:0]  DEST_HEIGHT_RST = 13'd140;
  localparam logic [STEP_W-1:0] STEP_Q16_RST    = 29'd65536;

  // Character codes with a fixed meaning.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // Ramp from dark to bright; the last entry is never reached.
  localparam int RAMP_LEVELS = 8;
  localparam int BRIGHT_STEP = 30;
  localparam int CHAN_COUNT  = 3;
  localparam logic [7:0] RAMP_CHARS [10] = '{
    8'd32, 8'd46, 8'd58, 8'd45, 8'd61, 8'd43, 8'd42, 8'd35, 8'd37, 8'd64
  };

  // The average (r+g+b)/3 reaches level k exactly when the sum reaches
  // 3*30*k, so the thresholds are applied to the sum and no divide is needed.
  function automatic logic [7:0] ramp_char(input logic [9:0] sum);
    logic [3:0] idx;
    idx = '0;
    for (int k = 1; k <= RAMP_LEVELS; k++) begin
      if (sum >= 10'(k * BRIGHT_STEP * CHAN_COUNT)) begin
        idx = idx + 4'd1;
      end
    end
    return RAMP_CHARS[idx];
  endfunction

endpackage

>>> rtl/core/pixel_stream_to_ascii_art_top.sv
// Top level of the pixel stream to ASCII art converter.
`timescale 1ns / 1ps

// Converts a raster stream of RGBA source pixels into character beats for a
// nearest-neighbour downscaled image in which only even destination rows are
// kept. Each kept pixel gives one beat with a ramp character and its colour
// (or an uncoloured space for a transparent pixel when alpha is enabled), and
// the last column of a kept row is followed by a newline beat. One pixel is
// accepted per clock while the output side does not stall; the counters and
// position accumulators update in the cycle of acceptance and the result
// lands in the output register. A pixel that ends a kept row holds the output
// register for two beats, so the input side takes no new pixel until the
// newline beat leaves. tlast marks the final beat belonging to one input pixel.
// Configuration writes take effect at once and do not clear the counters;
// they are meant to be issued while the block is idle.
module pixel_stream_to_ascii_art_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [ps2a_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [ps2a_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Source pixel stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ps2a_pkg::PIX_DATA_W-1:0]    s_axis_tdata,  // red, green, blue, alpha
  // Character stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ps2a_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // char_code, out_red, out_green, out_blue
  output logic                               m_axis_tuser,  // color_valid
  output logic                               m_axis_tlast
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = (CW + 1 > ps2a_pkg::POS_W - ps2a_pkg::POS_FRAC_W) ?
                      CW + 1 : ps2a_pkg::POS_W - ps2a_pkg::POS_FRAC_W;
  localparam int PW = ps2a_pkg::POS_W;
  localparam int NW = ps2a_pkg::DIM_W;

  // Configuration registers
  logic [NW-1:0]                   src_width_q, src_height_q, dest_width_q, dest_height_q;
  logic [ps2a_pkg::STEP_W-1:0]     step_q;
  logic                            alpha_en_q;

  // Scan state
  logic [CW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [NW-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [PW-1:0] col_pos_q, col_pos_d, row_pos_q, row_pos_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic       out_nl_q, out_nl_d;
  logic       out_phase_q, out_phase_d;
  logic       out_cv_q, out_cv_d;
  logic [7:0] out_char_q, out_char_d;
  logic [7:0] out_r_q, out_r_d, out_g_q, out_g_d, out_b_q, out_b_d;

  logic [7:0]    pix_r, pix_g, pix_b, pix_a;
  logic [DW-1:0] sw_ext, sh_ext, sw_eff, sh_eff;
  logic          row_sel, col_sel, emit, nl, transparent;
  logic          col_end, row_end;
  logic          in_fire, beat_done, item_done;
  logic [9:0]    bright_sum;

  assign pix_r = s_axis_tdata[7:0];
  assign pix_g = s_axis_tdata[15:8];
  assign pix_b = s_axis_tdata[23:16];
  assign pix_a = s_axis_tdata[31:24];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= ps2a_pkg::SRC_WIDTH_RST;
      src_height_q  <= ps2a_pkg::SRC_HEIGHT_RST;
      dest_width_q  <= ps2a_pkg::DEST_WIDTH_RST;
      dest_height_q <= ps2a_pkg::DEST_HEIGHT_RST;
      step_q        <= ps2a_pkg::STEP_Q16_RST;
      alpha_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ps2a_pkg::REG_SRC_WIDTH:   src_width_q   <= cfg_data_i[NW-1:0];
        ps2a_pkg::REG_SRC_HEIGHT:  src_height_q  <= cfg_data_i[NW-1:0];
        ps2a_pkg::REG_DEST_WIDTH:  dest_width_q  <= cfg_data_i[NW-1:0];
        ps2a_pkg::REG_DEST_HEIGHT: dest_height_q <= cfg_data_i[NW-1:0];
        ps2a_pkg::REG_STEP_Q16:    step_q        <= cfg_data_i[ps2a_pkg::STEP_W-1:0];
        ps2a_pkg::REG_ALPHA_EN:    alpha_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Source size with zero taken as one and large values capped.
  always_comb begin
    sw_ext = DW'(src_width_q);
    sh_ext = DW'(src_height_q);
    if (sw_ext == '0) begin
      sw_eff = DW'(1);
    end else if (sw_ext > DW'(MAX_DIM)) begin
      sw_eff = DW'(MAX_DIM);
    end else begin
      sw_eff = sw_ext;
    end
    if (sh_ext == '0) begin
      sh_eff = DW'(1);
    end else if (sh_ext > DW'(MAX_DIM)) begin
      sh_eff = DW'(MAX_DIM);
    end else begin
      sh_eff = sh_ext;
    end
  end

  // Selection of the current source pixel for the destination grid.
  assign row_sel = (DW'(src_row_q) == DW'(row_pos_q[PW-1:ps2a_pkg::POS_FRAC_W])) &&
                   (dst_row_q < dest_height_q);
  assign col_sel = (DW'(src_col_q) == DW'(col_pos_q[PW-1:ps2a_pkg::POS_FRAC_W])) &&
                   (dst_col_q < dest_width_q);
  assign emit    = row_sel && col_sel && !dst_row_q[0];
  assign nl      = ({1'b0, dst_col_q} + {{NW{1'b0}}, 1'b1}) == {1'b0, dest_width_q};
  assign col_end = (DW'(src_col_q) + DW'(1)) >= sw_eff;
  assign row_end = (DW'(src_row_q) + DW'(1)) >= sh_eff;

  assign transparent = alpha_en_q && (pix_a == 8'd0);
  assign bright_sum  = 10'(pix_r) + 10'(pix_g) + 10'(pix_b);

  // Handshakes: a new pixel enters when the output register is free or
  // its final beat leaves in this cycle.
  assign beat_done     = out_valid_q && m_axis_tready;
  assign item_done     = beat_done && (out_phase_q || !out_nl_q);
  assign s_axis_tready = !out_valid_q || item_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Counter and accumulator update for an accepted pixel.
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (in_fire) begin
      if (col_sel) begin
        dst_col_d = dst_col_q + NW'(1);
        col_pos_d = col_pos_q + PW'(step_q);
      end
      if (col_end) begin
        src_col_d = '0;
        dst_col_d = '0;
        col_pos_d = '0;
        if (row_sel) begin
          dst_row_d = dst_row_q + NW'(1);
          row_pos_d = row_pos_q + PW'(step_q);
        end
        if (row_end) begin
          src_row_d = '0;
          dst_row_d = '0;
          row_pos_d = '0;
        end else begin
          src_row_d = src_row_q + CW'(1);
        end
      end else begin
        src_col_d = src_col_q + CW'(1);
      end
    end
  end

  // Output register: main character beat, then an optional newline beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_nl_d    = out_nl_q;
    out_phase_d = out_phase_q;
    out_cv_d    = out_cv_q;
    out_char_d  = out_char_q;
    out_r_d     = out_r_q;
    out_g_d     = out_g_q;
    out_b_d     = out_b_q;
    if (in_fire) begin
      out_valid_d = emit;
      out_nl_d    = nl;
      out_phase_d = 1'b0;
      if (transparent) begin
        out_char_d = ps2a_pkg::CHAR_SPACE;
        out_r_d    = 8'd0;
        out_g_d    = 8'd0;
        out_b_d    = 8'd0;
        out_cv_d   = 1'b0;
      end else begin
        out_char_d = ps2a_pkg::ramp_char(bright_sum);
        out_r_d    = pix_r;
        out_g_d    = pix_g;
        out_b_d    = pix_b;
        out_cv_d   = 1'b1;
      end
    end else if (item_done) begin
      out_valid_d = 1'b0;
      out_phase_d = 1'b0;
    end else if (beat_done) begin
      out_phase_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      dst_col_q   <= '0;
      dst_row_q   <= '0;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      out_valid_q <= 1'b0;
      out_nl_q    <= 1'b0;
      out_phase_q <= 1'b0;
    end else begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      dst_col_q   <= dst_col_d;
      dst_row_q   <= dst_row_d;
      col_pos_q   <= col_pos_d;
      row_pos_q   <= row_pos_d;
      out_valid_q <= out_valid_d;
      out_nl_q    <= out_nl_d;
      out_phase_q <= out_phase_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_cv_q   <= out_cv_d;
    out_char_q <= out_char_d;
    out_r_q    <= out_r_d;
    out_g_q    <= out_g_d;
    out_b_q    <= out_b_d;
  end

  // The newline beat carries no colour.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_phase_q ?
                         {24'd0, ps2a_pkg::CHAR_NEWLINE} :
                         {out_b_q, out_g_q, out_r_q, out_char_q};
  assign m_axis_tuser  = out_phase_q ? 1'b0 : out_cv_q;
  assign m_axis_tlast  = out_phase_q || !out_nl_q;

endmodule

>>> rtl/core/ps2a_checker.sv
// Port-level checker for the ASCII art converter and its bind statement.
`timescale 1ns / 1ps

module ps2a_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ps2a_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // A stalled character beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled character beat changed");

  // A newline is always the uncoloured final beat of its pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] == ps2a_pkg::CHAR_NEWLINE) |->
      m_axis_tlast && !m_axis_tuser)
    else $error("newline beat not last or coloured");

  // A character beat that is not last is followed directly by its newline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[7:0] == ps2a_pkg::CHAR_NEWLINE))
    else $error("missing newline after end of row character");

  // Uncoloured beats carry zero colour fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[31:8] == 24'd0))
    else $error("uncoloured beat has nonzero colour");

endmodule

bind pixel_stream_to_ascii_art_top ps2a_checker u_ps2a_checker (.*);

>>> bench/pixel_stream_to_ascii_art_top_tb.sv
// Self-checking testbench for the pixel stream to ASCII art converter.
`timescale 1ns / 1ps

module pixel_stream_to_ascii_art_top_tb;
  import ps2a_pkg::*;

  localparam int unsigned DIM_CAP       = 4096;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned LEVEL_SPAN    = 30;
  localparam int unsigned TOP_LEVEL     = 8;
  localparam int unsigned RESET_PROBES  = 2;
  localparam logic        TYPED         = 1'b1;
  localparam logic        PREDICTED     = 1'b0;

  // Brightness ramp, darkest first.
  localparam logic [7:0] GLYPHS [9] = '{" ", ".", ":", "-", "=", "+", "*", "#", "%"};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       colored;
    logic       tail;
  } char_beat_t;

  // One directed pixel; the glyph is only used when the row is typed.
  typedef struct packed {
    pixel_t     px;
    logic       typed;
    logic [7:0] glyph;
    logic       colored;
  } probe_t;

  // One register setting and the number of pixels streamed under it.
  typedef struct packed {
    logic [12:0] src_w;
    logic [12:0] src_h;
    logic [12:0] dst_w;
    logic [12:0] dst_h;
    logic [28:0] step;
    logic        alpha_en;
    logic [15:0] pixels;
    logic        calm;
  } scene_t;

  // The first two pixels run with the reset settings, the rest with an 8x3 image
  // whose rows 0 and 2 are kept and row 1 is dropped.
  localparam probe_t PROBES [24] = '{
    {8'd0,   8'd0,   8'd0,   8'd0,   TYPED,     CHAR_SPACE, 1'b1},
    {8'd255, 8'd255, 8'd255, 8'd0,   TYPED,     "%",        1'b1},
    {8'd255, 8'd255, 8'd255, 8'd0,   TYPED,     CHAR_SPACE, 1'b0},
    {8'd29,  8'd29,  8'd29,  8'd1,   TYPED,     CHAR_SPACE, 1'b1},
    {8'd30,  8'd30,  8'd30,  8'd128, TYPED,     ".",        1'b1},
    {8'd59,  8'd59,  8'd59,  8'd200, TYPED,     ".",        1'b1},
    {8'd60,  8'd61,  8'd59,  8'd255, TYPED,     ":",        1'b1},
    {8'd239, 8'd240, 8'd241, 8'd255, PREDICTED, 8'd0,       1'b0},
    {8'd255, 8'd0,   8'd0,   8'd0,   PREDICTED, 8'd0,       1'b0},
    {8'd0,   8'd255, 8'd0,   8'd255, PREDICTED, 8'd0,       1'b0},
    {8'd0,   8'd0,   8'd255, 8'd1,   PREDICTED, 8'd0,       1'b0},
    {8'd170, 8'd85,  8'd170, 8'd85,  PREDICTED, 8'd0,       1'b0},
    {8'd85,  8'd170, 8'd85,  8'd170, PREDICTED, 8'd0,       1'b0},
    {8'd1,   8'd2,   8'd4,   8'd8,   PREDICTED, 8'd0,       1'b0},
    {8'd16,  8'd32,  8'd64,  8'd128, PREDICTED, 8'd0,       1'b0},
    {8'd254, 8'd253, 8'd251, 8'd247, PREDICTED, 8'd0,       1'b0},
    {8'd89,  8'd89,  8'd89,  8'd255, TYPED,     ":",        1'b1},
    {8'd90,  8'd90,  8'd90,  8'd255, TYPED,     "-",        1'b1},
    {8'd120, 8'd120, 8'd119, 8'd255, TYPED,     "-",        1'b1},
    {8'd150, 8'd150, 8'd150, 8'd255, TYPED,     "+",        1'b1},
    {8'd149, 8'd149, 8'd149, 8'd255, TYPED,     "=",        1'b1},
    {8'd180, 8'd180, 8'd180, 8'd255, TYPED,     "*",        1'b1},
    {8'd210, 8'd210, 8'd210, 8'd255, TYPED,     "#",        1'b1},
    {8'd240, 8'd255, 8'd0,   8'd0,   PREDICTED, 8'd0,       1'b0}
  };

  localparam scene_t PROBE_SCENE =
    {13'd8, 13'd3, 13'd8, 13'd3, 29'd65536, 1'b1, 16'd0, 1'b0};

  // Random phases. Counters carry over from one phase to the next.
  localparam scene_t SCENES [17] = '{
    {13'd16,   13'd8,    13'd16,   13'd8,    29'd65536,     1'b1, 16'd128, 1'b0},
    {13'd32,   13'd12,   13'd8,    13'd6,    29'd262144,    1'b0, 16'd192, 1'b0},
    {13'd10,   13'd10,   13'd20,   13'd20,   29'd32768,     1'b1, 16'd200, 1'b0},
    {13'd12,   13'd9,    13'd5,    13'd7,    29'd98304,     1'b0, 16'd108, 1'b0},
    {13'd1,    13'd40,   13'd1,    13'd40,   29'd65536,     1'b1, 16'd40,  1'b0},
    {13'd0,    13'd0,    13'd1,    13'd4,    29'd65536,     1'b0, 16'd40,  1'b0},
    {13'd4096, 13'd2,    13'd4096, 13'd4096, 29'd65536,     1'b1, 16'd150, 1'b0},
    {13'd8191, 13'd8191, 13'd8191, 13'd8191, 29'd65536,     1'b0, 16'd100, 1'b0},
    {13'd6,    13'd5,    13'd8191, 13'd8191, 29'd268435456, 1'b1, 16'd60,  1'b0},
    {13'd5,    13'd3,    13'd4096, 13'd4096, 29'd65536,     1'b1, 16'd60,  1'b0},
    {13'd20,   13'd6,    13'd3,    13'd2,    29'd65536,     1'b0, 16'd240, 1'b1},
    {13'd9,    13'd9,    13'd9,    13'd9,    29'd65535,     1'b0, 16'd162, 1'b1},
    {13'd8,    13'd6,    13'd8,    13'd6,    29'd0,         1'b1, 16'd96,  1'b0},
    {13'd6,    13'd4,    13'd0,    13'd5,    29'd65536,     1'b1, 16'd24,  1'b0},
    {13'd7,    13'd3,    13'd7,    13'd0,    29'd65536,     1'b0, 16'd21,  1'b0},
    {13'd24,   13'd16,   13'd17,   13'd11,   29'd92000,     1'b1, 16'd200, 1'b0},
    {13'd4,    13'd4,    13'd2,    13'd2,    29'h1FFFFFFF,  1'b0, 16'd32,  1'b0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_DATA_W-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // Mirror of the registers and the scan state.
  logic [12:0] cfg_src_w = 13'd640;
  logic [12:0] cfg_src_h = 13'd480;
  logic [12:0] cfg_dst_w = 13'd600;
  logic [12:0] cfg_dst_h = 13'd140;
  logic [28:0] cfg_step  = 29'd65536;
  logic        cfg_alpha = 1'b0;
  logic [11:0] src_col   = '0;
  logic [11:0] src_row   = '0;
  logic [12:0] dst_col   = '0;
  logic [12:0] dst_row   = '0;
  logic [29:0] col_pos   = '0;
  logic [29:0] row_pos   = '0;

  char_beat_t  pending_chars [$];
  int unsigned bad_beats   = 0;
  int unsigned cycle_count = 0;
  logic        steady_flow = 1'b0;

  pixel_stream_to_ascii_art_top #(
    .MAX_DIM(DIM_CAP)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a source dimension the way the block does: zero acts as one.
  function automatic int unsigned clamp_dim(input logic [12:0] dim);
    if (dim == 13'd0) begin
      return 1;
    end
    return (dim > DIM_CAP) ? DIM_CAP : int'(dim);
  endfunction

  // Work out the beats one accepted pixel causes and advance the scan state.
  // A typed row replaces the computed character beat with the one in the table.
  function automatic void render_pixel(input pixel_t px, input logic typed,
                                       input char_beat_t typed_beat);
    int unsigned width, height, bright, level;
    logic        row_hit, col_hit, line_end;
    char_beat_t  glyph_beat;
    width   = clamp_dim(cfg_src_w);
    height  = clamp_dim(cfg_src_h);
    row_hit = (src_row == (row_pos >> 16)) && (dst_row < cfg_dst_h);
    col_hit = (src_col == (col_pos >> 16)) && (dst_col < cfg_dst_w);

    // Only even destination rows produce characters.
    if (row_hit && col_hit && !dst_row[0]) begin
      line_end = (dst_col + 1 == cfg_dst_w);
      if (cfg_alpha && px.alpha == 8'd0) begin
        glyph_beat = {CHAR_SPACE, 24'd0, 1'b0, !line_end};
      end else begin
        bright = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        level  = bright / LEVEL_SPAN;
        if (level > TOP_LEVEL) begin
          level = TOP_LEVEL;
        end
        glyph_beat = {GLYPHS[level], px.red, px.green, px.blue, 1'b1, !line_end};
      end
      pending_chars.push_back(typed ? typed_beat : glyph_beat);
      if (line_end) begin
        pending_chars.push_back({CHAR_NEWLINE, 24'd0, 1'b0, 1'b1});
      end
    end

    if (col_hit) begin
      dst_col = dst_col + 13'd1;
      col_pos = 30'(col_pos + cfg_step);
    end

    // End of a source row, and of the image.
    if (src_col + 1 >= width) begin
      src_col = '0;
      dst_col = '0;
      col_pos = '0;
      if (row_hit) begin
        dst_row = dst_row + 13'd1;
        row_pos = 30'(row_pos + cfg_step);
      end
      if (src_row + 1 >= height) begin
        src_row = '0;
        dst_row = '0;
        row_pos = '0;
      end else begin
        src_row = src_row + 12'd1;
      end
    end else begin
      src_col = src_col + 12'd1;
    end
  endfunction

  // Random pixel: mostly full range, some transparent, some gray near a threshold.
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned pick, gray;
    px   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      px.alpha = 8'd0;
    end else if (pick < 35) begin
      gray     = LEVEL_SPAN * $urandom_range(1, TOP_LEVEL) - 2 + $urandom_range(0, 3);
      px.red   = 8'(gray);
      px.green = 8'(gray);
      px.blue  = 8'(gray);
    end
    return px;
  endfunction

  // Write one register at the next edge and update the mirror.
  task automatic write_reg(input cfg_reg_e idx, input logic [28:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:   cfg_src_w = value[12:0];
      REG_SRC_HEIGHT:  cfg_src_h = value[12:0];
      REG_DEST_WIDTH:  cfg_dst_w = value[12:0];
      REG_DEST_HEIGHT: cfg_dst_h = value[12:0];
      REG_STEP_Q16:    cfg_step  = value;
      REG_ALPHA_EN:    cfg_alpha = value[0];
      default: ;
    endcase
  endtask

  // Wait for the block to drain, then load a full register setting.
  task automatic apply_scene(input scene_t sc);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_SRC_WIDTH, 29'(sc.src_w));
    write_reg(REG_SRC_HEIGHT, 29'(sc.src_h));
    write_reg(REG_DEST_WIDTH, 29'(sc.dst_w));
    write_reg(REG_DEST_HEIGHT, 29'(sc.dst_h));
    write_reg(REG_STEP_Q16, sc.step);
    write_reg(REG_ALPHA_EN, 29'(sc.alpha_en));
    cfg_we_i    <= 1'b0;
    steady_flow <= sc.calm;
  endtask

  // Offer one pixel beat, with a random gap first unless the flow is steady, and predict on acceptance.
  task automatic send_pixel(input pixel_t px, input logic typed, input char_beat_t typed_beat);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.alpha, px.blue, px.green, px.red};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    render_pixel(px, typed, typed_beat);
  endtask

  task automatic note_mismatch(input string what, input char_beat_t want, input char_beat_t seen);
    bad_beats++;
    if (bad_beats <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected char %0d rgb %0d/%0d/%0d color %0b last %0b, got char %0d rgb %0d/%0d/%0d color %0b last %0b",
               $time, what, want.glyph, want.red, want.green, want.blue, want.colored,
               want.tail, seen.glyph, seen.red, seen.green, seen.blue, seen.colored, seen.tail);
    end
  endtask

  // Character side: random back-pressure unless the flow is steady, and a check of every accepted beat.
  always @(posedge clk_i) begin : char_sink
    char_beat_t seen, want;
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
              m_axis_tdata[31:24], m_axis_tuser, m_axis_tlast};
      if (pending_chars.size() == 0) begin
        note_mismatch("beat with nothing expected", '0, seen);
      end else begin
        want = pending_chars.pop_front();
        if (seen.glyph !== want.glyph || seen.red !== want.red ||
            seen.green !== want.green || seen.blue !== want.blue ||
            seen.colored !== want.colored || seen.tail !== want.tail) begin
          note_mismatch("character beat mismatch", want, seen);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pixel_stream_to_ascii_art_top] ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed pixels, random phases, drain and verdict.
  initial begin
    probe_t     probe;
    char_beat_t typed_beat;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(PROBES); i++) begin
      if (i == RESET_PROBES) begin
        apply_scene(PROBE_SCENE);
      end
      probe      = PROBES[i];
      typed_beat = {probe.glyph,
                    probe.colored ? {probe.px.red, probe.px.green, probe.px.blue} : 24'd0,
                    probe.colored, 1'b1};
      send_pixel(probe.px, probe.typed, typed_beat);
    end

    for (int s = 0; s < $size(SCENES); s++) begin
      apply_scene(SCENES[s]);
      for (int n = 0; n < int'(SCENES[s].pixels); n++) begin
        send_pixel(random_pixel(), PREDICTED, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_beats == 0 && pending_chars.size() == 0) begin
      $display("[pixel_stream_to_ascii_art_top] OK");
    end else begin
      $display("[pixel_stream_to_ascii_art_top] ERROR");
    end
    $finish;
  end

endmodule
